@@ hw/rtl/levelset_cell_area_fraction_macros.svh @@
`ifndef LEVELSET_CELL_AREA_FRACTION_MACROS_SVH
`define LEVELSET_CELL_AREA_FRACTION_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger
`define LCAF_ASSERT_IMP(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
		else $error(msg);

// Check that a condition holds in the cycle after its trigger
`define LCAF_ASSERT_NXT(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
		else $error(msg);

`endif

@@ hw/rtl/lcaf_pkg.sv @@
`default_nettype none

package lcaf_pkg;

	// Sample and fraction widths
	localparam int DIST_W     = 16;
	localparam int FRAC_W     = 16;
	localparam int QUO_BITS   = FRAC_W;
	localparam int DIV_STAGES = QUO_BITS;
	localparam int REM_W      = DIST_W + FRAC_W - 1;
	localparam int SUM_W      = DIST_W + 2;
	localparam int PROD_W     = 2 * FRAC_W;

	localparam logic [FRAC_W-1:0] ONE_Q15 = FRAC_W'(32768);

	typedef logic signed [DIST_W-1:0] dist_t;
	typedef logic [FRAC_W-1:0]        frac_t;
	typedef logic [2:0]               kind_t;

	// Result formation codes
	localparam kind_t K_EDGE  = 3'd0;
	localparam kind_t K_ZERO  = 3'd1;
	localparam kind_t K_ONE   = 3'd2;
	localparam kind_t K_C1    = 3'd3;
	localparam kind_t K_C3    = 3'd4;
	localparam kind_t K_ADJ   = 3'd5;
	localparam kind_t K_JOIN  = 3'd6;
	localparam kind_t K_SPLIT = 3'd7;

	typedef struct packed {
		logic [DIST_W-1:0] num;
		logic [DIST_W-1:0] den;
	} div_req_t;

	// Numerator and denominator of an edge fraction; the constant cases become 1/1 and 0/1
	function automatic div_req_t edge_ops(dist_t a, dist_t b);
		div_req_t               r;
		logic signed [DIST_W:0] ax;
		logic signed [DIST_W:0] bx;
		logic signed [DIST_W:0] t;
		ax = {a[DIST_W-1], a};
		bx = {b[DIST_W-1], b};
		r.num = DIST_W'(0);
		r.den = DIST_W'(1);
		if (a[DIST_W-1] && b[DIST_W-1]) begin
			r.num = DIST_W'(1);
		end else if (a[DIST_W-1]) begin
			t = -ax;
			r.num = t[DIST_W-1:0];
			t = bx - ax;
			r.den = t[DIST_W-1:0];
		end else if (b[DIST_W-1]) begin
			t = -bx;
			r.num = t[DIST_W-1:0];
			t = ax - bx;
			r.den = t[DIST_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lcaf_in_if.sv @@
`default_nettype none

interface lcaf_in_if import lcaf_pkg::*;;
	logic  valid;
	logic  ready;
	logic  action;
	dist_t corner_bottom_left;
	dist_t corner_bottom_right;
	dist_t corner_top_left;
	dist_t corner_top_right;

	modport source(output valid, output action, output corner_bottom_left,
		output corner_bottom_right, output corner_top_left, output corner_top_right,
		input ready);
	modport sink(input valid, input action, input corner_bottom_left,
		input corner_bottom_right, input corner_top_left, input corner_top_right,
		output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lcaf_out_if.sv @@
`default_nettype none

interface lcaf_out_if import lcaf_pkg::*;;
	logic  valid;
	logic  ready;
	frac_t inside_fraction;

	modport source(output valid, output inside_fraction, input ready);
	modport sink(input valid, input inside_fraction, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lcaf_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per register stage
module lcaf_div import lcaf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [DIST_W-1:0] num,
	input  wire logic [DIST_W-1:0] den,
	output frac_t                  quo
);

	logic [REM_W-1:0]  rem_s [1:DIV_STAGES];
	logic [DIST_W-1:0] den_s [1:DIV_STAGES];
	frac_t             quo_s [1:DIV_STAGES];

	logic [REM_W-1:0] rem0;
	assign rem0 = REM_W'(num) << (FRAC_W - 1);

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		logic [REM_W-1:0]  r_in;
		logic [DIST_W-1:0] d_in;
		frac_t             q_in;
		logic [REM_W-1:0]  dsh;
		logic              fits;

		if (j == 0) begin : g_first
			assign r_in = rem0;
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[j];
			assign d_in = den_s[j];
			assign q_in = quo_s[j];
		end

		// Try the divisor at this bit's weight
		assign dsh  = REM_W'(d_in) << (DIV_STAGES - 1 - j);
		assign fits = r_in >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= fits ? r_in - dsh : r_in;
				den_s[j+1] <= d_in;
				quo_s[j+1] <= q_in | (fits ? (FRAC_W'(1) << (DIV_STAGES - 1 - j)) : '0);
			end
		end
	end

	assign quo = quo_s[DIV_STAGES];

endmodule

`default_nettype wire

@@ hw/rtl/levelset_cell_area_fraction.sv @@
// Takes one sample beat per cycle while the output register is free or taken;
// the 16-stage quotient pipeline sets the depth.
// The whole pipeline advances when the output register is empty or taken.
// Reset (arst_n low) clears all valid bits at once; data registers are not reset.
`default_nettype none

`include "levelset_cell_area_fraction_macros.svh"

module levelset_cell_area_fraction import lcaf_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lcaf_in_if.sink     samples,
	lcaf_out_if.source  fraction
);

	logic en;
	logic vld_s20;

	// Advance when the output register is free or being taken
	assign en            = !vld_s20 || fraction.ready;
	assign samples.ready = en;

	// Count negative corners, rotate, and form the kind and the edge divisions
	dist_t                  ring [4];
	dist_t                  l [4];
	logic [3:0]             neg;
	logic [2:0]             cnt;
	logic [1:0]             k;
	logic                   found;
	logic                   hit;
	logic signed [SUM_W-1:0] sum0;
	kind_t                  kind0;
	div_req_t               req0 [4];

	always_comb begin
		ring[0] = samples.corner_bottom_left;
		ring[1] = samples.corner_bottom_right;
		ring[2] = samples.corner_top_right;
		ring[3] = samples.corner_top_left;
		cnt  = '0;
		sum0 = '0;
		for (int i = 0; i < 4; i++) begin
			neg[i] = ring[i][DIST_W-1];
			cnt    = cnt + 3'(neg[i]);
			sum0   = sum0 + SUM_W'(ring[i]);
		end
		k     = '0;
		found = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (cnt == 3'd3) begin
				hit = !neg[2'(i)];
			end else if (cnt == 3'd2) begin
				hit = neg[2'(i)] && (neg[2'(i) + 2'd1] || neg[2'(i) + 2'd2]);
			end else begin
				hit = neg[2'(i)];
			end
			if (hit && !found) begin
				k     = 2'(i);
				found = 1'b1;
			end
		end
		for (int i = 0; i < 4; i++) begin
			l[i] = ring[2'(i) + k];
		end
		if (!samples.action) begin
			kind0 = K_EDGE;
		end else begin
			unique case (cnt)
				3'd0:    kind0 = K_ZERO;
				3'd1:    kind0 = K_C1;
				3'd2:    kind0 = l[1][DIST_W-1] ? K_ADJ : (sum0 < 0 ? K_JOIN : K_SPLIT);
				3'd3:    kind0 = K_C3;
				default: kind0 = K_ONE;
			endcase
		end
		req0[0] = samples.action ? edge_ops(l[0], l[3])
			: edge_ops(samples.corner_bottom_left, samples.corner_bottom_right);
		req0[1] = edge_ops(l[0], l[1]);
		req0[2] = edge_ops(l[2], l[3]);
		req0[3] = edge_ops(l[2], l[1]);
	end

	logic     vld_s1;
	kind_t    kind_s1;
	div_req_t req_s1 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind0;
			req_s1  <= req0;
		end
	end

	// Four quotient lanes
	frac_t quo [4];

	for (genvar g = 0; g < 4; g++) begin : g_lane
		lcaf_div u_div (
			.clk (clk),
			.en  (en),
			.num (req_s1[g].num),
			.den (req_s1[g].den),
			.quo (quo[g])
		);
	end

	// Carry valid and kind alongside the quotient lanes
	logic  vld_div_s  [DIV_STAGES];
	kind_t kind_div_s [DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++) begin
				vld_div_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_div_s[0] <= vld_s1;
			for (int i = 1; i < DIV_STAGES; i++) begin
				vld_div_s[i] <= vld_div_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_div_s[0] <= kind_s1;
			for (int i = 1; i < DIV_STAGES; i++) begin
				kind_div_s[i] <= kind_div_s[i-1];
			end
		end
	end

	// Select triangle operands and the linear result
	kind_t            kind_d;
	frac_t            a0;
	frac_t            b0;
	frac_t            a1;
	frac_t            b1;
	frac_t            lin;
	logic [FRAC_W:0]  adj_sum;

	assign kind_d  = kind_div_s[DIV_STAGES-1];
	assign adj_sum = {1'b0, quo[0]} + {1'b0, quo[3]};

	always_comb begin
		a0  = quo[0];
		b0  = quo[1];
		a1  = '0;
		b1  = '0;
		lin = '0;
		unique case (kind_d)
			K_EDGE:  lin = quo[0];
			K_ONE:   lin = ONE_Q15;
			K_ADJ:   lin = adj_sum[FRAC_W:1];
			K_C3: begin
				a0 = ONE_Q15 - quo[0];
				b0 = ONE_Q15 - quo[1];
			end
			K_JOIN: begin
				a0 = ONE_Q15 - quo[0];
				b0 = ONE_Q15 - quo[2];
				a1 = ONE_Q15 - quo[1];
				b1 = ONE_Q15 - quo[3];
			end
			K_SPLIT: begin
				a1 = quo[2];
				b1 = quo[3];
			end
			default: lin = '0;
		endcase
	end

	logic  vld_s18;
	kind_t kind_s18;
	frac_t a0_s18, b0_s18, a1_s18, b1_s18, lin_s18;

	logic  vld_s19;
	kind_t kind_s19;
	logic [PROD_W-1:0] p0_s19, p1_s19;
	frac_t lin_s19;

	frac_t res_s20;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s18 <= 1'b0;
			vld_s19 <= 1'b0;
			vld_s20 <= 1'b0;
		end else if (en) begin
			vld_s18 <= vld_div_s[DIV_STAGES-1];
			vld_s19 <= vld_s18;
			vld_s20 <= vld_s19;
		end
	end

	// Multiply, then combine the halved products
	frac_t t0;
	frac_t t1;
	frac_t res;

	assign t0 = p0_s19[PROD_W-1:FRAC_W];
	assign t1 = p1_s19[PROD_W-1:FRAC_W];

	always_comb begin
		unique case (kind_s19)
			K_C1:    res = t0;
			K_C3:    res = ONE_Q15 - t0;
			K_JOIN:  res = ONE_Q15 - (t0 + t1);
			K_SPLIT: res = t0 + t1;
			default: res = lin_s19;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s18 <= kind_d;
			a0_s18   <= a0;
			b0_s18   <= b0;
			a1_s18   <= a1;
			b1_s18   <= b1;
			lin_s18  <= lin;
			kind_s19 <= kind_s18;
			p0_s19   <= PROD_W'(a0_s18) * PROD_W'(b0_s18);
			p1_s19   <= PROD_W'(a1_s18) * PROD_W'(b1_s18);
			lin_s19  <= lin_s18;
			res_s20  <= res;
		end
	end

	assign fraction.valid           = vld_s20;
	assign fraction.inside_fraction = res_s20;

	`LCAF_ASSERT_IMP(a_frac_range, clk, arst_n, fraction.valid, fraction.inside_fraction <= ONE_Q15, "fraction above one")
	`LCAF_ASSERT_NXT(a_beat_enters, clk, arst_n, samples.valid && samples.ready, vld_s1, "accepted beat lost at entry")
	`LCAF_ASSERT_IMP(a_quo_range, clk, arst_n, vld_div_s[DIV_STAGES-1], (quo[0] <= ONE_Q15) && (quo[1] <= ONE_Q15) && (quo[2] <= ONE_Q15) && (quo[3] <= ONE_Q15), "edge quotient above one")
	`LCAF_ASSERT_IMP(a_ready_empty, clk, arst_n, !fraction.valid, samples.ready, "pipeline stalled with empty output")

endmodule

`default_nettype wire
